@@ hdl/aac_asc_pkg.sv @@
// ----------------------------------------------------------------------------
// aac_asc_pkg
// shared types, codes and the sampling rate table of the audio config parser
// ----------------------------------------------------------------------------
package aac_asc_pkg;

    localparam int unsigned OT_W   = 7;
    localparam int unsigned RATE_W = 24;
    localparam int unsigned CHAN_W = 4;
    localparam int unsigned STAT_W = 2;
    localparam int unsigned CNT_W  = 5;

    localparam logic [4:0] OT_ESCAPE   = 5'd31;
    localparam logic [6:0] OT_ESC_BASE = 7'd32;
    localparam logic [6:0] OT_SBR      = 7'd5;
    localparam logic [6:0] OT_PS       = 7'd29;
    localparam logic [4:0] OT_ER_BSAC  = 5'd22;
    localparam logic [3:0] RATE_ESCAPE = 4'd15;
    localparam logic [3:0] RATE_RSV_LO = 4'd13;
    localparam logic [3:0] RATE_RSV_HI = 4'd14;

    localparam logic [CNT_W-1:0] LEN_OT   = 5'd5;
    localparam logic [CNT_W-1:0] LEN_ESC  = 5'd6;
    localparam logic [CNT_W-1:0] LEN_IDX  = 5'd4;
    localparam logic [CNT_W-1:0] LEN_LIT  = 5'd24;
    localparam logic [CNT_W-1:0] LEN_CHAN = 5'd4;
    localparam logic [CNT_W-1:0] LEN_NONE = 5'd0;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_RESERVED = 2'd1,
        ST_SHORT    = 2'd2
    } t_status;

    typedef enum logic [11:0] {
        PH_OT        = 12'b0000_0000_0001,
        PH_OT_ESC    = 12'b0000_0000_0010,
        PH_RATE_IDX  = 12'b0000_0000_0100,
        PH_RATE_LIT  = 12'b0000_0000_1000,
        PH_CHAN      = 12'b0000_0001_0000,
        PH_XRATE_IDX = 12'b0000_0010_0000,
        PH_XRATE_LIT = 12'b0000_0100_0000,
        PH_XOT       = 12'b0000_1000_0000,
        PH_XOT_ESC   = 12'b0001_0000_0000,
        PH_XCHAN     = 12'b0010_0000_0000,
        PH_DONE      = 12'b0100_0000_0000,
        PH_ERROR     = 12'b1000_0000_0000
    } t_phase;

    function automatic logic [RATE_W-1:0] rate_lookup(input logic [3:0] idx);
        logic [RATE_W-1:0] r;
        case (idx)
            4'd0:    r = 24'd96000;
            4'd1:    r = 24'd88200;
            4'd2:    r = 24'd64000;
            4'd3:    r = 24'd48000;
            4'd4:    r = 24'd44100;
            4'd5:    r = 24'd32000;
            4'd6:    r = 24'd24000;
            4'd7:    r = 24'd22050;
            4'd8:    r = 24'd16000;
            4'd9:    r = 24'd12000;
            4'd10:   r = 24'd11025;
            4'd11:   r = 24'd8000;
            4'd12:   r = 24'd7350;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

@@ hdl/aac_asc_if.sv @@
// ----------------------------------------------------------------------------
// aac_asc_if
// valid/ready channels for config bytes in and parsed results out
// ----------------------------------------------------------------------------
interface aac_asc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] config_byte;
    logic       final_byte;

    modport source (output valid, output config_byte, output final_byte, input ready);
    modport sink   (input valid, input config_byte, input final_byte, output ready);
endinterface

interface aac_asc_out_if;
    logic        valid;
    logic        ready;
    logic [6:0]  object_type;
    logic [23:0] sample_rate_hz;
    logic [3:0]  channel_config;
    logic        sbr_present;
    logic        ps_present;
    logic [6:0]  ext_object_type;
    logic [23:0] ext_sample_rate_hz;
    logic [3:0]  ext_channel_config;
    logic [1:0]  parse_status;

    modport source (
        output valid, output object_type, output sample_rate_hz, output channel_config,
        output sbr_present, output ps_present, output ext_object_type,
        output ext_sample_rate_hz, output ext_channel_config, output parse_status,
        input ready
    );
    modport sink (
        input valid, input object_type, input sample_rate_hz, input channel_config,
        input sbr_present, input ps_present, input ext_object_type,
        input ext_sample_rate_hz, input ext_channel_config, input parse_status,
        output ready
    );
endinterface

@@ hdl/aac_audio_specific_config_parser_core.sv @@
// Parses an MPEG-4 AudioSpecificConfig arriving one byte per beat, MSB first.
// It takes one byte every cycle unless stalled: a byte is registered, then all
// eight of its bits are walked through the field state machine from the input
// register, one beat per cycle; the result register loads as the final beat
// advances. Only a waiting result that is not taken stalls the
// input, and then only when the next final byte has reached the parse stage.
// After each result the parser is back in its reset state for the next record.
// ----------------------------------------------------------------------------
// aac_audio_specific_config_parser_core
// byte-wide AudioSpecificConfig field parser with registered result
// ----------------------------------------------------------------------------
module aac_audio_specific_config_parser_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    aac_asc_in_if.sink    i_in,
    aac_asc_out_if.source o_out
);
    import aac_asc_pkg::*;

    // input stage
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_final;

    // parse state
    t_phase              r_phase,    n_phase;
    logic [CNT_W-1:0]    r_left,     n_left;
    logic [RATE_W-1:0]   r_acc,      n_acc;
    logic [OT_W-1:0]     r_ot,       n_ot;
    logic [RATE_W-1:0]   r_rate,     n_rate;
    logic [CHAN_W-1:0]   r_chan,     n_chan;
    logic [OT_W-1:0]     r_xot,      n_xot;
    logic [RATE_W-1:0]   r_xrate,    n_xrate;
    logic [CHAN_W-1:0]   r_xchan,    n_xchan;
    logic                r_sbr,      n_sbr;
    logic                r_ps,       n_ps;
    t_status             n_status;

    // result register
    logic                r_out_valid;
    logic [OT_W-1:0]     r_out_ot;
    logic [RATE_W-1:0]   r_out_rate;
    logic [CHAN_W-1:0]   r_out_chan;
    logic                r_out_sbr;
    logic                r_out_ps;
    logic [OT_W-1:0]     r_out_xot;
    logic [RATE_W-1:0]   r_out_xrate;
    logic [CHAN_W-1:0]   r_out_xchan;
    t_status             r_out_status;

    logic out_free;
    logic advance;

    assign out_free   = !r_out_valid || o_out.ready;
    // a final beat needs room in the result register
    assign advance    = r_in_valid && (!r_in_final || out_free);
    assign i_in.ready = !r_in_valid || advance;

    always_comb begin
        n_phase = r_phase;
        n_left  = r_left;
        n_acc   = r_acc;
        n_ot    = r_ot;
        n_rate  = r_rate;
        n_chan  = r_chan;
        n_xot   = r_xot;
        n_xrate = r_xrate;
        n_xchan = r_xchan;
        n_sbr   = r_sbr;
        n_ps    = r_ps;
        for (int i = 7; i >= 0; i--) begin
            if (n_phase != PH_DONE && n_phase != PH_ERROR && n_left != LEN_NONE) begin
                n_acc  = {n_acc[RATE_W-2:0], r_in_byte[3'(i)]};
                n_left = n_left - 5'd1;
                if (n_left == LEN_NONE) begin
                    case (n_phase)
                        PH_OT: begin
                            if (n_acc[4:0] == OT_ESCAPE) begin
                                n_phase = PH_OT_ESC;
                                n_left  = LEN_ESC;
                            end else begin
                                n_ot    = {2'b00, n_acc[4:0]};
                                n_sbr   = n_sbr || n_ot == OT_SBR || n_ot == OT_PS;
                                n_ps    = n_ps || n_ot == OT_PS;
                                n_phase = PH_RATE_IDX;
                                n_left  = LEN_IDX;
                            end
                        end
                        PH_OT_ESC: begin
                            n_ot    = OT_ESC_BASE + {1'b0, n_acc[5:0]};
                            n_sbr   = n_sbr || n_ot == OT_SBR || n_ot == OT_PS;
                            n_ps    = n_ps || n_ot == OT_PS;
                            n_phase = PH_RATE_IDX;
                            n_left  = LEN_IDX;
                        end
                        PH_RATE_IDX, PH_XRATE_IDX: begin
                            if (n_acc[3:0] == RATE_ESCAPE) begin
                                n_phase = (n_phase == PH_RATE_IDX) ? PH_RATE_LIT : PH_XRATE_LIT;
                                n_left  = LEN_LIT;
                            end else if (n_acc[3:0] inside {RATE_RSV_LO, RATE_RSV_HI}) begin
                                n_phase = PH_ERROR;
                                n_left  = LEN_NONE;
                            end else if (n_phase == PH_RATE_IDX) begin
                                n_rate  = rate_lookup(n_acc[3:0]);
                                n_phase = PH_CHAN;
                                n_left  = LEN_CHAN;
                            end else begin
                                n_xrate = rate_lookup(n_acc[3:0]);
                                n_phase = PH_XOT;
                                n_left  = LEN_OT;
                            end
                        end
                        PH_RATE_LIT: begin
                            n_rate  = n_acc;
                            n_phase = PH_CHAN;
                            n_left  = LEN_CHAN;
                        end
                        PH_CHAN: begin
                            n_chan = n_acc[3:0];
                            if (n_sbr) begin
                                n_phase = PH_XRATE_IDX;
                                n_left  = LEN_IDX;
                            end else begin
                                n_phase = PH_DONE;
                                n_left  = LEN_NONE;
                            end
                        end
                        PH_XRATE_LIT: begin
                            n_xrate = n_acc;
                            n_phase = PH_XOT;
                            n_left  = LEN_OT;
                        end
                        PH_XOT: begin
                            if (n_acc[4:0] == OT_ESCAPE) begin
                                n_phase = PH_XOT_ESC;
                                n_left  = LEN_ESC;
                            end else begin
                                n_xot = {2'b00, n_acc[4:0]};
                                if (n_acc[4:0] == OT_ER_BSAC) begin
                                    n_phase = PH_XCHAN;
                                    n_left  = LEN_CHAN;
                                end else begin
                                    n_phase = PH_DONE;
                                    n_left  = LEN_NONE;
                                end
                            end
                        end
                        PH_XOT_ESC: begin
                            n_xot   = OT_ESC_BASE + {1'b0, n_acc[5:0]};
                            n_phase = PH_DONE;
                            n_left  = LEN_NONE;
                        end
                        PH_XCHAN: begin
                            n_xchan = n_acc[3:0];
                            n_phase = PH_DONE;
                            n_left  = LEN_NONE;
                        end
                        default: begin
                            n_phase = n_phase;
                        end
                    endcase
                    n_acc = '0;
                end
            end
        end
        if (n_phase == PH_ERROR) begin
            n_status = ST_RESERVED;
        end else if (n_phase == PH_DONE) begin
            n_status = ST_OK;
        end else begin
            n_status = ST_SHORT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.ready) begin
            r_in_byte  <= i_in.config_byte;
            r_in_final <= i_in.final_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (advance && r_in_final)) begin
            // back to the start of a record
            r_phase <= PH_OT;
            r_left  <= LEN_OT;
            r_acc   <= '0;
            r_ot    <= '0;
            r_rate  <= '0;
            r_chan  <= '0;
            r_xot   <= '0;
            r_xrate <= '0;
            r_xchan <= '0;
            r_sbr   <= 1'b0;
            r_ps    <= 1'b0;
        end else if (advance) begin
            r_phase <= n_phase;
            r_left  <= n_left;
            r_acc   <= n_acc;
            r_ot    <= n_ot;
            r_rate  <= n_rate;
            r_chan  <= n_chan;
            r_xot   <= n_xot;
            r_xrate <= n_xrate;
            r_xchan <= n_xchan;
            r_sbr   <= n_sbr;
            r_ps    <= n_ps;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_final) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && r_in_final) begin
            r_out_ot     <= n_ot;
            r_out_rate   <= n_rate;
            r_out_chan   <= n_chan;
            r_out_sbr    <= n_sbr;
            r_out_ps     <= n_ps;
            r_out_xot    <= n_xot;
            r_out_xrate  <= n_xrate;
            r_out_xchan  <= n_xchan;
            r_out_status <= n_status;
        end
    end

    assign o_out.valid              = r_out_valid;
    assign o_out.object_type        = r_out_ot;
    assign o_out.sample_rate_hz     = r_out_rate;
    assign o_out.channel_config     = r_out_chan;
    assign o_out.sbr_present        = r_out_sbr;
    assign o_out.ps_present         = r_out_ps;
    assign o_out.ext_object_type    = r_out_xot;
    assign o_out.ext_sample_rate_hz = r_out_xrate;
    assign o_out.ext_channel_config = r_out_xchan;
    assign o_out.parse_status       = r_out_status;

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// checks the audio specific config parser against its own field-walking model
// ----------------------------------------------------------------------------
// Byte records are built field by field (plain and escaped object types,
// tabled, literal and reserved rate indices, SBR/PS extensions), then sent
// whole, cut short, padded with extra bytes, or as noise. Each accepted byte
// runs through a bit-serial model of the parser, and every result beat is
// compared field by field with the oldest expected record.
// ----------------------------------------------------------------------------
module tb;
    import aac_asc_pkg::*;

    localparam int QUIET_LIMIT = 2000;

    // sampling rates by index, index 0 in the low bits
    localparam logic [12:0][RATE_W-1:0] RATE_HZ = {
        24'd7350,  24'd8000,  24'd11025, 24'd12000, 24'd16000, 24'd22050, 24'd24000,
        24'd32000, 24'd44100, 24'd48000, 24'd64000, 24'd88200, 24'd96000
    };

    typedef struct {
        logic [OT_W-1:0]   object_type;
        logic [RATE_W-1:0] sample_rate_hz;
        logic [CHAN_W-1:0] channel_config;
        logic              sbr_present;
        logic              ps_present;
        logic [OT_W-1:0]   ext_object_type;
        logic [RATE_W-1:0] ext_sample_rate_hz;
        logic [CHAN_W-1:0] ext_channel_config;
        t_status           parse_status;
    } t_asc_fields;

    logic i_clk;
    logic i_rst_n;

    aac_asc_in_if  in_if ();
    aac_asc_out_if out_if ();

    aac_audio_specific_config_parser_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // parser model state
    t_phase            walk_phase;
    logic [CNT_W-1:0]  walk_bits_left;
    logic [RATE_W-1:0] walk_acc;
    t_asc_fields       pending_cfg;

    t_asc_fields expected_cfgs[$];
    bit          rec_bits[$];

    int  err_count;
    int  bytes_sent;
    int  quiet_cycles;
    int  ready_hold;
    bit  idling_on;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input logic [23:0] got,
                                   input logic [23:0] want);
        $display("tb: mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // ---------------- model ----------------

    function automatic void start_field(input t_phase ph, input logic [CNT_W-1:0] n);
        walk_phase     = ph;
        walk_bits_left = n;
        walk_acc       = '0;
    endfunction

    function automatic void clear_walk();
        start_field(PH_OT, LEN_OT);
        pending_cfg.object_type        = '0;
        pending_cfg.sample_rate_hz     = '0;
        pending_cfg.channel_config     = '0;
        pending_cfg.sbr_present        = 1'b0;
        pending_cfg.ps_present         = 1'b0;
        pending_cfg.ext_object_type    = '0;
        pending_cfg.ext_sample_rate_hz = '0;
        pending_cfg.ext_channel_config = '0;
        pending_cfg.parse_status       = ST_OK;
    endfunction

    function automatic void take_object_type(input logic [OT_W-1:0] ot);
        pending_cfg.object_type = ot;
        if (ot == OT_SBR || ot == OT_PS) pending_cfg.sbr_present = 1'b1;
        if (ot == OT_PS) pending_cfg.ps_present = 1'b1;
        start_field(PH_RATE_IDX, LEN_IDX);
    endfunction

    function automatic void take_rate_index(input logic [3:0] idx, input bit is_ext);
        if (idx == RATE_ESCAPE) begin
            start_field(is_ext ? PH_XRATE_LIT : PH_RATE_LIT, LEN_LIT);
        end else if (idx == RATE_RSV_LO || idx == RATE_RSV_HI) begin
            start_field(PH_ERROR, LEN_NONE);
        end else if (is_ext) begin
            pending_cfg.ext_sample_rate_hz = RATE_HZ[idx];
            start_field(PH_XOT, LEN_OT);
        end else begin
            pending_cfg.sample_rate_hz = RATE_HZ[idx];
            start_field(PH_CHAN, LEN_CHAN);
        end
    endfunction

    function automatic void close_field(input logic [RATE_W-1:0] v);
        case (walk_phase)
            PH_OT: begin
                if (v[4:0] == OT_ESCAPE) start_field(PH_OT_ESC, LEN_ESC);
                else take_object_type({2'b00, v[4:0]});
            end
            PH_OT_ESC:    take_object_type(OT_ESC_BASE + {1'b0, v[5:0]});
            PH_RATE_IDX:  take_rate_index(v[3:0], 1'b0);
            PH_RATE_LIT: begin
                pending_cfg.sample_rate_hz = v;
                start_field(PH_CHAN, LEN_CHAN);
            end
            PH_CHAN: begin
                pending_cfg.channel_config = v[3:0];
                if (pending_cfg.sbr_present) start_field(PH_XRATE_IDX, LEN_IDX);
                else start_field(PH_DONE, LEN_NONE);
            end
            PH_XRATE_IDX: take_rate_index(v[3:0], 1'b1);
            PH_XRATE_LIT: begin
                pending_cfg.ext_sample_rate_hz = v;
                start_field(PH_XOT, LEN_OT);
            end
            PH_XOT: begin
                if (v[4:0] == OT_ESCAPE) begin
                    start_field(PH_XOT_ESC, LEN_ESC);
                end else begin
                    pending_cfg.ext_object_type = {2'b00, v[4:0]};
                    if (v[4:0] == OT_ER_BSAC) start_field(PH_XCHAN, LEN_CHAN);
                    else start_field(PH_DONE, LEN_NONE);
                end
            end
            PH_XOT_ESC: begin
                pending_cfg.ext_object_type = OT_ESC_BASE + {1'b0, v[5:0]};
                start_field(PH_DONE, LEN_NONE);
            end
            PH_XCHAN: begin
                pending_cfg.ext_channel_config = v[3:0];
                start_field(PH_DONE, LEN_NONE);
            end
            default: ;
        endcase
    endfunction

    function automatic void parse_config_byte(input logic [7:0] b, input bit fin);
        t_asc_fields res;
        for (int i = 7; i >= 0; i--) begin
            if (walk_phase == PH_DONE || walk_phase == PH_ERROR || walk_bits_left == 0) break;
            walk_acc = {walk_acc[RATE_W-2:0], b[3'(i)]};
            walk_bits_left = walk_bits_left - 1'b1;
            if (walk_bits_left == 0) close_field(walk_acc);
        end
        if (fin) begin
            res = pending_cfg;
            if (walk_phase == PH_ERROR) res.parse_status = ST_RESERVED;
            else if (walk_phase == PH_DONE) res.parse_status = ST_OK;
            else res.parse_status = ST_SHORT;
            expected_cfgs.push_back(res);
            clear_walk();
        end
    endfunction

    // ---------------- record building ----------------

    function automatic void put_bits(input logic [23:0] v, input int n);
        for (int i = n - 1; i >= 0; i--) rec_bits.push_back(v[5'(i)]);
    endfunction

    function automatic void put_rate();
        int          pick;
        logic [3:0]  idx;
        pick = $urandom_range(0, 19);
        if (pick < 13) idx = 4'($urandom_range(0, 12));
        else if (pick < 17) idx = RATE_ESCAPE;
        else if (pick < 19) idx = 4'($urandom_range(13, 14));
        else idx = 4'($urandom_range(0, 15));
        put_bits({20'd0, idx}, 4);
        if (idx == RATE_ESCAPE) put_bits(24'($urandom), 24);
    endfunction

    function automatic void build_random_record();
        int         pick;
        logic [4:0] ot5;
        logic [4:0] xot5;
        rec_bits.delete();
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1:    ot5 = OT_SBR[4:0];
            2, 3:    ot5 = OT_PS[4:0];
            4:       ot5 = OT_ESCAPE;
            default: ot5 = 5'($urandom_range(0, 30));
        endcase
        put_bits({19'd0, ot5}, 5);
        if (ot5 == OT_ESCAPE) put_bits(24'($urandom_range(0, 63)), 6);
        put_rate();
        put_bits(24'($urandom_range(0, 15)), 4);
        if ({2'b00, ot5} == OT_SBR || {2'b00, ot5} == OT_PS) begin
            put_rate();
            pick = $urandom_range(0, 9);
            if (pick < 4) xot5 = OT_ER_BSAC;
            else if (pick < 6) xot5 = OT_ESCAPE;
            else xot5 = 5'($urandom_range(0, 30));
            put_bits({19'd0, xot5}, 5);
            if (xot5 == OT_ESCAPE) put_bits(24'($urandom_range(0, 63)), 6);
            else if (xot5 == OT_ER_BSAC) put_bits(24'($urandom_range(0, 15)), 4);
        end
    endfunction

    // ---------------- driving ----------------

    task automatic send_cfg_byte(input logic [7:0] b, input bit fin);
        int gap;
        gap = 0;
        if (idling_on && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 17);
        repeat (gap) begin
            @(negedge i_clk);
            in_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_if.valid       <= 1'b1;
        in_if.config_byte <= b;
        in_if.final_byte  <= fin;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        parse_config_byte(b, fin);
        bytes_sent++;
    endtask

    // pads to a byte, appends extra random bytes, sends the first keep bytes
    // (all when keep is 0) with the last one marked final
    task automatic send_record(input int extra, input int keep);
        int         nbytes;
        logic [7:0] b;
        while (rec_bits.size() % 8 != 0) rec_bits.push_back(1'($urandom));
        repeat (extra * 8) rec_bits.push_back(1'($urandom));
        nbytes = rec_bits.size() / 8;
        if (keep > 0 && keep < nbytes) nbytes = keep;
        for (int j = 0; j < nbytes; j++) begin
            for (int k = 0; k < 8; k++) b[3'(7 - k)] = rec_bits[j * 8 + k];
            send_cfg_byte(b, j == nbytes - 1);
        end
    endtask

    // ---------------- checking ----------------

    always @(posedge i_clk) begin : check_parsed_config
        t_asc_fields want;
        if (i_rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (expected_cfgs.size() == 0) begin
                report_mismatch("result beat with none expected", 24'd1, 24'd0);
            end else begin
                want = expected_cfgs.pop_front();
                if (out_if.object_type !== want.object_type)
                    report_mismatch("object_type", 24'(out_if.object_type),
                                    24'(want.object_type));
                if (out_if.sample_rate_hz !== want.sample_rate_hz)
                    report_mismatch("sample_rate_hz", out_if.sample_rate_hz,
                                    want.sample_rate_hz);
                if (out_if.channel_config !== want.channel_config)
                    report_mismatch("channel_config", 24'(out_if.channel_config),
                                    24'(want.channel_config));
                if (out_if.sbr_present !== want.sbr_present)
                    report_mismatch("sbr_present", 24'(out_if.sbr_present),
                                    24'(want.sbr_present));
                if (out_if.ps_present !== want.ps_present)
                    report_mismatch("ps_present", 24'(out_if.ps_present),
                                    24'(want.ps_present));
                if (out_if.ext_object_type !== want.ext_object_type)
                    report_mismatch("ext_object_type", 24'(out_if.ext_object_type),
                                    24'(want.ext_object_type));
                if (out_if.ext_sample_rate_hz !== want.ext_sample_rate_hz)
                    report_mismatch("ext_sample_rate_hz", out_if.ext_sample_rate_hz,
                                    want.ext_sample_rate_hz);
                if (out_if.ext_channel_config !== want.ext_channel_config)
                    report_mismatch("ext_channel_config", 24'(out_if.ext_channel_config),
                                    24'(want.ext_channel_config));
                if (out_if.parse_status !== want.parse_status)
                    report_mismatch("parse_status", 24'(out_if.parse_status),
                                    24'(want.parse_status));
            end
        end
    end

    // result side back-pressure in bursts
    always @(negedge i_clk) begin
        if (idling_on && ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
            out_if.ready <= 1'b0;
            ready_hold   <= $urandom_range(0, 16);
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
                (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb: FAIL");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ---------------- tests ----------------

    task automatic test_directed_records();
        // plain record, every field at its low end
        rec_bits.delete();
        put_bits(24'd0, 5); put_bits(24'd0, 4); put_bits(24'd0, 4);
        send_record(0, 0);
        // highest unescaped type, last table entry, highest channel config
        rec_bits.delete();
        put_bits(24'd30, 5); put_bits(24'd12, 4); put_bits(24'd15, 4);
        send_record(0, 0);
        // escaped type to 95, literal rate at full scale
        rec_bits.delete();
        put_bits(24'd31, 5); put_bits(24'd63, 6); put_bits(24'd15, 4);
        put_bits(24'hFFFFFF, 24);
        put_bits(24'd7, 4);
        send_record(0, 0);
        // reserved base rate index, trailing byte must be ignored
        rec_bits.delete();
        put_bits(24'd2, 5); put_bits(24'd13, 4);
        send_record(1, 0);
        // sbr+ps with reserved extension rate index
        rec_bits.delete();
        put_bits(24'd29, 5); put_bits(24'd3, 4); put_bits(24'd1, 4); put_bits(24'd14, 4);
        send_record(0, 0);
        // sbr with er bsac extension, so extension channel config is read
        rec_bits.delete();
        put_bits(24'd5, 5); put_bits(24'd6, 4); put_bits(24'd2, 4); put_bits(24'd3, 4);
        put_bits(24'd22, 5); put_bits(24'd15, 4);
        send_record(0, 0);
        // sbr+ps with escaped extension type at its base
        rec_bits.delete();
        put_bits(24'd29, 5); put_bits(24'd11, 4); put_bits(24'd2, 4); put_bits(24'd0, 4);
        put_bits(24'd31, 5); put_bits(24'd0, 6);
        send_record(0, 0);
        // record ends inside the escaped object type
        rec_bits.delete();
        put_bits(24'hFF, 8);
        send_record(0, 0);
    endtask

    task automatic test_random_records(input int n_bytes);
        int stop_at;
        int mode;
        int total;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            build_random_record();
            total = (rec_bits.size() + 7) / 8;
            mode  = $urandom_range(0, 9);
            if (mode < 7) begin
                send_record(($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0, 0);
            end else if (mode < 9) begin
                send_record(0, $urandom_range(1, total - 1));
            end else begin
                rec_bits.delete();
                send_record($urandom_range(1, 6), 0);
            end
        end
    endtask

    initial begin
        in_if.valid       = 1'b0;
        in_if.config_byte = '0;
        in_if.final_byte  = 1'b0;
        out_if.ready      = 1'b0;
        i_rst_n           = 1'b0;
        err_count         = 0;
        bytes_sent        = 0;
        quiet_cycles      = 0;
        ready_hold        = 0;
        idling_on         = 1'b1;
        clear_walk();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_records();
        test_random_records(370);
        // closing stretch at full rate on both sides
        idling_on = 1'b0;
        test_random_records(60);

        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (expected_cfgs.size() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
